// ===== sv/sbe_pkg.sv =====
// Shared types, constants and helper functions of the stereo bass enhancer.
// Holds the tanh/3 lookup table, built at elaboration. No dependencies.
package sbe_pkg;

   // Fixed-point formats: internal Q2.22 in 24 bits, product of shared unit
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC        = SAMPLE_BITS + 6;
   localparam int IW          = SAMPLE_BITS + 8;
   localparam int OP_W        = 26;
   localparam int PROD_W      = 2 * OP_W;
   localparam int NUM_CHANNELS = 2;

   // Register indexes
   localparam logic [1:0] REG_SUB_LP  = 2'd0;
   localparam logic [1:0] REG_BAND_LP = 2'd1;
   localparam logic [1:0] REG_BAND_HP = 2'd2;
   localparam logic [1:0] REG_INTENS  = 2'd3;

   // Register reset values
   localparam logic [15:0] SUB_LP_RESET  = 16'd745;
   localparam logic [15:0] BAND_LP_RESET = 16'd838;
   localparam logic [15:0] BAND_HP_RESET = 16'd373;
   localparam logic [15:0] INTENS_RESET  = 16'd32768;

   // Arithmetic constants
   localparam int SMOOTH_COEFF = 655;
   localparam int SUB_GAIN     = 19661;
   localparam int AMT_MAX      = 32768;

   // tanh table: DEPTH+1 entries of tanh(t)/3 over t in [0, SPAN]
   localparam int TANH_DEPTH = 256;
   localparam int TANH_SPAN  = 8;
   localparam int TANH_SCALE = 3 * TANH_DEPTH / TANH_SPAN;
   localparam int TIDX_W     = $clog2(TANH_DEPTH + 1);
   localparam logic [63:0] TANH_STEP = (64'(2 * TANH_SPAN) << 32) / 64'(TANH_DEPTH);

   typedef logic [IW-1:0] tanh_tab_type [0:TANH_DEPTH];

   // Restoring long division, used only while building the table
   function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic tanh_tab_type build_tanh();
      tanh_tab_type t;
      logic [63:0] stp;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] e;
      logic [63:0] num;
      logic [63:0] den;
      stp  = TANH_STEP;
      r    = 64'd1 << 32;
      term = 64'd1 << 32;
      e    = 64'd1 << 32;
      // exp(-step) from a Q32 series
      for (int k = 1; k <= 24; k++) begin
         term = long_div((term * stp) >> 32, 64'(k));
         if ((k & 1) == 1) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      for (int i = 0; i <= TANH_DEPTH; i++) begin
         num  = ((64'd1 << 32) - e) << FRAC;
         den  = ((64'd1 << 32) + e) * 64'd3;
         t[i] = IW'(long_div(num + (den >> 1), den));
         e    = (e * r) >> 32;
      end
      return t;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh();

   // Round half up, then arithmetic shift right
   function automatic logic signed [PROD_W-1:0] round_shr(input logic signed [PROD_W-1:0] v,
                                                          input int n);
      logic signed [PROD_W-1:0] half;
      half = PROD_W'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   // Saturate to the internal width
   function automatic logic signed [IW-1:0] sat_iw(input logic signed [31:0] v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = (32'sd1 <<< (IW - 1)) - 32'sd1;
      lo = -hi - 32'sd1;
      if (v > hi) begin
         return IW'(hi);
      end else if (v < lo) begin
         return IW'(lo);
      end
      return IW'(v);
   endfunction

   // Saturate to the sample width
   function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [31:0] v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
      lo = -hi - 32'sd1;
      if (v > hi) begin
         return SAMPLE_BITS'(hi);
      end else if (v < lo) begin
         return SAMPLE_BITS'(lo);
      end
      return SAMPLE_BITS'(v);
   endfunction

endpackage

// ===== sv/sbe_mul.sv =====
// Shared signed multiplier of the bass enhancer, product registered.
// Depends on sbe_pkg for operand and product widths.
module sbe_mul (
   input  logic                               clock,
   input  logic signed [sbe_pkg::OP_W-1:0]    op_a,
   input  logic signed [sbe_pkg::OP_W-1:0]    op_b,
   output logic signed [sbe_pkg::PROD_W-1:0]  product_ff
);

   // One product per cycle, registered
   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

endmodule

// ===== sv/stereo_bass_enhancer.sv =====
// Top level of the stereo bass enhancer: sequencer, state and registers.
// Depends on sbe_pkg and sbe_mul.
//
//   port group | dir | tdata        | tuser        | tlast
//   req_       | in  | sample       | channel      | buffer_end
//   rsp_       | out | sample_out   | channel_out  | buffer_end_out
//   csr_       | in  | write data, index 0..3, write enable
//
// Each item passes through accept, 20 sequencer steps (ten products through
// the single shared multiplier, an operand step and a result step each), then the output load.
// req_tready is high only while the sequencer is idle.
// Reset (synchronous) clears registers to defaults and channel state to zero.
// A stalled result holds the sequencer in its last state until taken.
module stereo_bass_enhancer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sbe_pkg::SAMPLE_BITS-1:0]   req_tdata,   // sample
   input  logic                              req_tuser,   // channel
   input  logic                              req_tlast,   // buffer_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sbe_pkg::SAMPLE_BITS-1:0]   rsp_tdata,   // sample_out
   output logic                              rsp_tuser,   // channel_out
   output logic                              rsp_tlast,   // buffer_end_out
   input  logic                              csr_we,
   input  logic [1:0]                        csr_addr,
   input  logic [15:0]                       csr_wdata
);

   localparam int IW = sbe_pkg::IW;
   localparam int OW = sbe_pkg::OP_W;
   localparam int PW = sbe_pkg::PROD_W;
   localparam int SB = sbe_pkg::SAMPLE_BITS;
   localparam int NC = sbe_pkg::NUM_CHANNELS;
   localparam int TIDX_W_L = sbe_pkg::TIDX_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [4:0] LAST_STEP = 5'd19;

   // product slots
   localparam logic [3:0] M_SUBAMT = 4'd0;
   localparam logic [3:0] M_BASS   = 4'd1;
   localparam logic [3:0] M_SMOOTH = 4'd2;
   localparam logic [3:0] M_ENV    = 4'd3;
   localparam logic [3:0] M_MIX    = 4'd4;
   localparam logic [3:0] M_BLP    = 4'd5;
   localparam logic [3:0] M_BHP    = 4'd6;
   localparam logic [3:0] M_POS    = 4'd7;
   localparam logic [3:0] M_INTERP = 4'd8;
   localparam logic [3:0] M_EXCITE = 4'd9;

   // configuration registers
   logic [15:0] sub_lp_ff, band_lp_ff, band_hp_ff, intens_ff;

   // sequencer
   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0] rsp_data_ff, rsp_data_in;
   logic       rsp_user_ff, rsp_user_in, rsp_last_ff, rsp_last_in;

   // per-channel state
   logic signed [IW-1:0] bl_ff [NC], bl_in [NC];
   logic                 pp_ff [NC], pp_in [NC];
   logic                 ph_ff [NC], ph_in [NC];
   logic signed [IW-1:0] sm_ff [NC], sm_in [NC];
   logic signed [IW-1:0] blp_ff [NC], blp_in [NC];
   logic signed [IW-1:0] bhp_ff [NC], bhp_in [NC];

   // working registers of one item
   logic                 ch_ff, ch_in, last_ff, last_in;
   logic signed [IW-1:0] xin_ff, xin_in;
   logic [17:0]          subamt_ff, subamt_in;
   logic signed [OW-1:0] env_ff, env_in;
   logic signed [OW-1:0] mix_ff, mix_in;
   logic signed [IW-1:0] y1_ff, y1_in;
   logic signed [IW-1:0] band_ff, band_in;
   logic signed [OW-1:0] mag_ff, mag_in;
   logic [IW-1:0]        lo_ff, lo_in, dif_ff, dif_in;
   logic [sbe_pkg::FRAC-1:0] frac_ff, frac_in;
   logic signed [OW-1:0] t_ff, t_in;
   logic [SB-1:0]        res_ff, res_in;

   logic signed [OW-1:0] op_a, op_b;
   logic signed [PW-1:0] product_ff;

   // combinational helpers
   logic [3:0]           slot;
   logic [16:0]          exsamt;
   logic [16:0]          ex_raw;
   logic [33:0]          sa_raw;
   logic signed [IW-1:0] pole_new;
   logic signed [IW-1:0] pole_s;
   logic signed [IW-1:0] sq;
   logic [TIDX_W_L-1:0]  ic, ih;
   logic signed [OW-1:0] interp;
   logic signed [IW-1:0] y2;
   logic signed [IW-1:0] band_new;

   assign slot = step_ff[4:1];
   assign ex_raw = (17'(intens_ff) + 17'd1) >> 1;
   assign exsamt = (ex_raw > 17'(sbe_pkg::AMT_MAX)) ? 17'(sbe_pkg::AMT_MAX) : ex_raw;
   assign sq = ph_ff[ch_ff] ? IW'(1 <<< sbe_pkg::FRAC) : -IW'(1 <<< sbe_pkg::FRAC);

   sbe_mul u_mul (
      .clock      (clock),
      .op_a       (op_a),
      .op_b       (op_b),
      .product_ff (product_ff)
   );

   // shared one-pole update, from the filter state chosen by the slot
   always_comb begin
      case (slot)
         M_BASS:   pole_s = bl_ff[ch_ff];
         M_SMOOTH: pole_s = sm_ff[ch_ff];
         M_BLP:    pole_s = blp_ff[ch_ff];
         default:  pole_s = bhp_ff[ch_ff];
      endcase
      pole_new = sbe_pkg::sat_iw(32'(pole_s) + 32'(sbe_pkg::round_shr(product_ff, 16)));
   end

   // table indexes for interpolation
   always_comb begin
      if (product_ff[PW-1:sbe_pkg::FRAC] >= (PW - sbe_pkg::FRAC)'(sbe_pkg::TANH_DEPTH)) begin
         ic = TIDX_W_L'(sbe_pkg::TANH_DEPTH);
         ih = TIDX_W_L'(sbe_pkg::TANH_DEPTH);
      end else begin
         ic = TIDX_W_L'(product_ff[PW-1:sbe_pkg::FRAC]);
         ih = ic + TIDX_W_L'(1);
      end
   end

   assign sa_raw   = 34'(product_ff[32:0]) + 34'd32768;
   assign interp   = OW'(lo_ff) + OW'(product_ff[47:sbe_pkg::FRAC]);
   assign y2       = sbe_pkg::sat_iw(32'(y1_ff) + 32'(sbe_pkg::round_shr(product_ff, 15)));
   assign band_new = sbe_pkg::sat_iw(32'(blp_ff[ch_ff]) - 32'(pole_new));

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      bl_in        = bl_ff;
      pp_in        = pp_ff;
      ph_in        = ph_ff;
      sm_in        = sm_ff;
      blp_in       = blp_ff;
      bhp_in       = bhp_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      xin_in       = xin_ff;
      subamt_in    = subamt_ff;
      env_in       = env_ff;
      mix_in       = mix_ff;
      y1_in        = y1_ff;
      band_in      = band_ff;
      mag_in       = mag_ff;
      lo_in        = lo_ff;
      dif_in       = dif_ff;
      frac_in      = frac_ff;
      t_in         = t_ff;
      res_in       = res_ff;
      op_a         = '0;
      op_b         = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ch_in    = req_tuser;
               last_in  = req_tlast;
               xin_in   = IW'(signed'(req_tdata)) <<< 7;
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
            if (!step_ff[0]) begin
               // operand selection for this slot
               case (slot)
                  M_SUBAMT: begin
                     op_a = OW'(signed'({1'b0, intens_ff}));
                     op_b = OW'(sbe_pkg::SUB_GAIN);
                  end
                  M_BASS: begin
                     op_a = OW'(signed'({1'b0, sub_lp_ff}));
                     op_b = OW'(32'(xin_ff) - 32'(bl_ff[ch_ff]));
                  end
                  M_SMOOTH: begin
                     op_a = OW'(sbe_pkg::SMOOTH_COEFF);
                     op_b = OW'(32'(sq) - 32'(sm_ff[ch_ff]));
                  end
                  M_ENV: begin
                     op_a = OW'(sm_ff[ch_ff]);
                     op_b = env_ff;
                  end
                  M_MIX: begin
                     op_a = mix_ff;
                     op_b = OW'(signed'({1'b0, subamt_ff}));
                  end
                  M_BLP: begin
                     op_a = OW'(signed'({1'b0, band_lp_ff}));
                     op_b = OW'(32'(y1_ff) - 32'(blp_ff[ch_ff]));
                  end
                  M_BHP: begin
                     op_a = OW'(signed'({1'b0, band_hp_ff}));
                     op_b = OW'(32'(blp_ff[ch_ff]) - 32'(bhp_ff[ch_ff]));
                  end
                  M_POS: begin
                     op_a = mag_ff;
                     op_b = OW'(sbe_pkg::TANH_SCALE);
                  end
                  M_INTERP: begin
                     op_a = OW'(signed'({1'b0, dif_ff}));
                     op_b = OW'(signed'({1'b0, frac_ff}));
                  end
                  M_EXCITE: begin
                     op_a = OW'(32'(t_ff) - 32'(band_ff));
                     op_b = OW'(signed'({1'b0, exsamt}));
                  end
                  default: begin
                     op_a = '0;
                     op_b = '0;
                  end
               endcase
            end else begin
               // use the registered product
               case (slot)
                  M_SUBAMT: begin
                     subamt_in = (sa_raw[33:16] > 18'(sbe_pkg::AMT_MAX)) ?
                                 18'(sbe_pkg::AMT_MAX) : sa_raw[33:16];
                  end
                  M_BASS: begin
                     bl_in[ch_ff] = pole_new;
                     if ((pole_new > 0) != pp_ff[ch_ff]) begin
                        ph_in[ch_ff] = !ph_ff[ch_ff];
                        pp_in[ch_ff] = (pole_new > 0);
                     end
                     env_in = (pole_new < 0) ? -OW'(pole_new) : OW'(pole_new);
                  end
                  M_SMOOTH: sm_in[ch_ff] = pole_new;
                  M_ENV:    mix_in = OW'(sbe_pkg::round_shr(product_ff, sbe_pkg::FRAC));
                  M_MIX: begin
                     y1_in = sbe_pkg::sat_iw(32'(xin_ff) +
                                             32'(sbe_pkg::round_shr(product_ff, 15)));
                  end
                  M_BLP:    blp_in[ch_ff] = pole_new;
                  M_BHP: begin
                     bhp_in[ch_ff] = pole_new;
                     band_in       = band_new;
                     mag_in        = (band_new < 0) ? -OW'(band_new) : OW'(band_new);
                  end
                  M_POS: begin
                     frac_in = product_ff[sbe_pkg::FRAC-1:0];
                     lo_in   = sbe_pkg::TANH_TAB[ic];
                     dif_in  = sbe_pkg::TANH_TAB[ih] - sbe_pkg::TANH_TAB[ic];
                  end
                  M_INTERP: t_in = (band_ff < 0) ? -interp : interp;
                  M_EXCITE: res_in = sbe_pkg::sat_out((32'(y2) + 32'sd64) >>> 7);
                  default: ;
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_user_in  = ch_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NC; c++) begin
            bl_ff[c]  <= '0;
            pp_ff[c]  <= 1'b0;
            ph_ff[c]  <= 1'b0;
            sm_ff[c]  <= '0;
            blp_ff[c] <= '0;
            bhp_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         bl_ff        <= bl_in;
         pp_ff        <= pp_in;
         ph_ff        <= ph_in;
         sm_ff        <= sm_in;
         blp_ff       <= blp_in;
         bhp_ff       <= bhp_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_lp_ff  <= sbe_pkg::SUB_LP_RESET;
         band_lp_ff <= sbe_pkg::BAND_LP_RESET;
         band_hp_ff <= sbe_pkg::BAND_HP_RESET;
         intens_ff  <= sbe_pkg::INTENS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            sbe_pkg::REG_SUB_LP:  sub_lp_ff  <= csr_wdata;
            sbe_pkg::REG_BAND_LP: band_lp_ff <= csr_wdata;
            sbe_pkg::REG_BAND_HP: band_hp_ff <= csr_wdata;
            sbe_pkg::REG_INTENS:  intens_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      xin_ff      <= xin_in;
      subamt_ff   <= subamt_in;
      env_ff      <= env_in;
      mix_ff      <= mix_in;
      y1_ff       <= y1_in;
      band_ff     <= band_in;
      mag_ff      <= mag_in;
      lo_ff       <= lo_in;
      dif_ff      <= dif_in;
      frac_ff     <= frac_in;
      t_ff        <= t_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // an accepted item starts the sequencer at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_RUN && step_ff == 5'd0))
      else $error("sequencer did not start");
   // the step counter stays within the program
   a_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= LAST_STEP))
      else $error("step beyond program");
   // the last step always leads to the output load
   a_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff == LAST_STEP) |=> (state_ff == ST_DONE))
      else $error("missed output load");
   // leaving the output load always leaves a result pending
   a_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("result not presented");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the stereo bass enhancer: directed and random samples
// checked against a behavioural fixed-point predictor. Depends on sbe_pkg and the RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;  // sample
   logic req_tuser = 1'b0;       // channel
   logic req_tlast = 1'b0;       // buffer_end
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // sample_out
   logic rsp_tuser;              // channel_out
   logic rsp_tlast;              // buffer_end_out
   logic csr_we = 1'b0;
   logic [1:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   typedef struct packed {
      logic chan;
      logic [15:0] smp;
      logic last;
   } enh_item_type;

   enh_item_type enhanced_q[$];
   int errors = 0;
   longint cycles = 0;
   bit quiet = 0;   // no idling on either side

   // Predictor state and copy of the registers
   longint lp_k, band_lp_k, band_hp_k, strength;
   longint bass_s[2], sub_s[2], blp_s[2], bhp_s[2];
   bit was_pos[2], phase[2];
   longint tanh_q[0:sbe_pkg::TANH_DEPTH];

   stereo_bass_enhancer u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic longint rnd(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic longint pole(longint s, longint x, longint c);
      return clip(s + rnd(c * (x - s), 16), sbe_pkg::IW);
   endfunction

   // tanh/3 table rebuilt with unsigned 64-bit integer steps
   function automatic void make_tanh();
      logic [63:0] stp, r, term, e, num, den;
      stp = (64'(2 * sbe_pkg::TANH_SPAN) << 32) / 64'(sbe_pkg::TANH_DEPTH);
      r = 64'd1 << 32;
      term = r;
      e = r;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * stp) >> 32) / 64'(k);
         r = (k & 1) ? r - term : r + term;
      end
      for (int i = 0; i <= sbe_pkg::TANH_DEPTH; i++) begin
         num = ((64'd1 << 32) - e) << sbe_pkg::FRAC;
         den = ((64'd1 << 32) + e) * 64'd3;
         tanh_q[i] = longint'((num + den / 64'd2) / den);
         e = (e * r) >> 32;
      end
   endfunction

   function automatic longint tanh_third(longint band);
      longint mag, pos, idx, fr, v;
      mag = band < 0 ? -band : band;
      pos = mag * 3 * sbe_pkg::TANH_DEPTH / sbe_pkg::TANH_SPAN;
      idx = pos >>> sbe_pkg::FRAC;
      fr = pos & ((longint'(1) << sbe_pkg::FRAC) - 1);
      if (idx >= sbe_pkg::TANH_DEPTH) v = tanh_q[sbe_pkg::TANH_DEPTH];
      else v = tanh_q[idx] + (((tanh_q[idx + 1] - tanh_q[idx]) * fr) >>> sbe_pkg::FRAC);
      return band < 0 ? -v : v;
   endfunction

   function automatic void clear_state();
      lp_k = sbe_pkg::SUB_LP_RESET;
      band_lp_k = sbe_pkg::BAND_LP_RESET;
      band_hp_k = sbe_pkg::BAND_HP_RESET;
      strength = sbe_pkg::INTENS_RESET;
      for (int c = 0; c < 2; c++) begin
         bass_s[c] = 0; sub_s[c] = 0; blp_s[c] = 0; bhp_s[c] = 0;
         was_pos[c] = 0; phase[c] = 0;
      end
   endfunction

   // Computes the enhanced sample and advances the channel state
   function automatic logic [15:0] enhance(logic chan, logic [15:0] smp);
      longint sub_amt, ex_amt, xin, bass, sq, env, mix, y1, band, y2;
      bit pos;
      sub_amt = (strength * sbe_pkg::SUB_GAIN + 32768) >>> 16;
      ex_amt = (strength + 1) >>> 1;
      if (sub_amt > sbe_pkg::AMT_MAX) sub_amt = sbe_pkg::AMT_MAX;
      if (ex_amt > sbe_pkg::AMT_MAX) ex_amt = sbe_pkg::AMT_MAX;
      xin = longint'(signed'(smp)) * 128;
      bass = pole(bass_s[chan], xin, lp_k);
      bass_s[chan] = bass;
      pos = bass > 0;
      if (pos != was_pos[chan]) begin
         phase[chan] = !phase[chan];
         was_pos[chan] = pos;
      end
      sq = phase[chan] ? (longint'(1) << sbe_pkg::FRAC) : -(longint'(1) << sbe_pkg::FRAC);
      sub_s[chan] = pole(sub_s[chan], sq, sbe_pkg::SMOOTH_COEFF);
      env = bass < 0 ? -bass : bass;
      mix = rnd(sub_s[chan] * env, sbe_pkg::FRAC);
      mix = rnd(mix * sub_amt, 15);
      y1 = clip(xin + mix, sbe_pkg::IW);
      blp_s[chan] = pole(blp_s[chan], y1, band_lp_k);
      bhp_s[chan] = pole(bhp_s[chan], blp_s[chan], band_hp_k);
      band = clip(blp_s[chan] - bhp_s[chan], sbe_pkg::IW);
      y2 = clip(y1 + rnd((tanh_third(band) - band) * ex_amt, 15), sbe_pkg::IW);
      return 16'(clip(rnd(y2, 7), 16));
   endfunction

   // Sends one item, predicting its result on acceptance; valid stays up afterwards
   task automatic send_sample(logic chan, logic [15:0] smp, logic last);
      if (!quiet && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while (!quiet && $urandom_range(99) < 8);
      end
      req_tvalid <= 1'b1;
      req_tuser <= chan;
      req_tdata <= smp;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      enhanced_q.push_back('{chan, enhance(chan, smp), last});
      @(negedge clock);
   endtask

   // Drops valid and waits for every result, plus the sequencer's own latency
   task automatic drain();
      req_tvalid <= 1'b0;
      while (enhanced_q.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      drain();
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         sbe_pkg::REG_SUB_LP: lp_k = val;
         sbe_pkg::REG_BAND_LP: band_lp_k = val;
         sbe_pkg::REG_BAND_HP: band_hp_k = val;
         sbe_pkg::REG_INTENS: strength = val;
         default: ;
      endcase
   endtask

   // Result side: random stalls, compare each taken item with the oldest prediction
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      enh_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (enhanced_q.size() == 0) begin
            $error("unexpected result: sample_out %0d", signed'(rsp_tdata));
            errors++;
         end else begin
            want = enhanced_q.pop_front();
            if (rsp_tuser !== want.chan) begin
               $error("channel_out expected %0d got %0d", want.chan, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== want.smp) begin
               $error("sample_out expected %0d got %0d", signed'(want.smp),
                      signed'(rsp_tdata));
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("buffer_end_out expected %0d got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Extremes, sign changes at zero, both channels and end marks
   task automatic test_directed();
      logic [15:0] pat[8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                               16'h0001, 16'h7FFF, 16'h8000, 16'h0000};
      for (int i = 0; i < 8; i++) send_sample(i[0], pat[i], i == 7);
      for (int i = 0; i < 8; i++) send_sample(1'b0, pat[i], 1'b0);
      for (int i = 0; i < 6; i++) send_sample(1'b1, pat[7 - i], i[0]);
   endtask

   // Bursts of tone-like sequences with random content
   task automatic test_random(int n);
      int ph;
      logic chan;
      logic [15:0] amp;
      for (int i = 0; i < n; i++) begin
         chan = $urandom_range(1);
         if ($urandom_range(3) == 0) begin
            send_sample(chan, 16'($urandom), $urandom_range(1));
         end else begin
            amp = $urandom_range(32767);
            ph = $urandom_range(2, 40);
            send_sample(chan, ((i / ph) % 2) ? -amp : amp, $urandom_range(15) == 0);
         end
      end
   endtask

   // Register settings including extremes and an ignored-looking write
   task automatic test_settings();
      write_reg(sbe_pkg::REG_SUB_LP, 16'hFFFF);
      write_reg(sbe_pkg::REG_BAND_LP, 16'hFFFF);
      write_reg(sbe_pkg::REG_BAND_HP, 16'h0000);
      write_reg(sbe_pkg::REG_INTENS, 16'hFFFF);
      test_random(250);
      write_reg(sbe_pkg::REG_SUB_LP, 16'h0000);
      write_reg(sbe_pkg::REG_BAND_LP, 16'h0000);
      write_reg(sbe_pkg::REG_BAND_HP, 16'hFFFF);
      write_reg(sbe_pkg::REG_INTENS, 16'h0000);
      test_random(150);
      write_reg(sbe_pkg::REG_SUB_LP, 16'd6000);
      write_reg(sbe_pkg::REG_BAND_LP, 16'd9000);
      write_reg(sbe_pkg::REG_BAND_HP, 16'd2000);
      write_reg(sbe_pkg::REG_INTENS, 16'd40000);
      quiet = 1;
      test_random(250);
      quiet = 0;
      for (int k = 0; k < 4; k++) begin
         write_reg(sbe_pkg::REG_SUB_LP, 16'($urandom));
         write_reg(sbe_pkg::REG_BAND_LP, 16'($urandom));
         write_reg(sbe_pkg::REG_BAND_HP, 16'($urandom));
         write_reg(sbe_pkg::REG_INTENS, 16'($urandom));
         test_random(100);
      end
   endtask

   initial begin
      make_tanh();
      clear_state();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200);
      drain();
      test_random(200);
      test_settings();
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
